>>> sv/array_linked_list_manager_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the array linked list manager
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LINKED_LIST_MANAGER_MACROS_SVH
`define ARRAY_LINKED_LIST_MANAGER_MACROS_SVH

// check a property on every clock edge
`define ALLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that an antecedent is followed in the next cycle by a consequent
`define ALLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/allm_pkg.sv
// ----------------------------------------------------------------------------
// allm_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package allm_pkg;

  localparam int SLOTS_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int CAP_W         = 7;
  localparam int OP_W          = 4;
  localparam int ST_W          = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_BEFORE = 4'd2;
  localparam logic [OP_W-1:0] OP_INS_AFTER  = 4'd3;
  localparam logic [OP_W-1:0] OP_SORTED_INS = 4'd4;
  localparam logic [OP_W-1:0] OP_REMOVE     = 4'd5;
  localparam logic [OP_W-1:0] OP_RM_BEFORE  = 4'd6;
  localparam logic [OP_W-1:0] OP_RM_AFTER   = 4'd7;
  localparam logic [OP_W-1:0] OP_RM_BACK    = 4'd8;
  localparam logic [OP_W-1:0] OP_FIND       = 4'd9;
  localparam logic [OP_W-1:0] OP_MAX        = 4'd10;
  localparam logic [OP_W-1:0] OP_MIN        = 4'd11;
  localparam logic [OP_W-1:0] OP_SWAP_ENDS  = 4'd12;
  localparam logic [OP_W-1:0] OP_READ_SLOT  = 4'd13;

  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY       = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL        = 3'd3;
  localparam logic [ST_W-1:0] ST_NO_NEIGH    = 3'd4;
  localparam logic [ST_W-1:0] ST_NOT_IN_LIST = 3'd5;

  typedef enum logic [1:0] {RD_CUR, RD_LNK, RD_RS} rd_sel_e;

  typedef enum logic [2:0] {
    TGT_HEAD, TGT_S, TGT_C, TGT_P, TGT_PP, TGT_SEC, TGT_FST
  } tgt_e;

  typedef enum logic [2:0] {
    VAL_ZERO, VAL_S, VAL_C, VAL_L, VAL_RDN, VAL_SEC, VAL_FST, VAL_HEAD
  } val_e;

  typedef enum logic [1:0] {CLR_C, CLR_P, CLR_L} clr_e;

  typedef enum logic [2:0] {
    RS_S, RS_C, RS_P, RS_L, RS_BEST, RS_HEAD, RS_ADDR
  } rs_e;

  typedef struct packed {
    logic            load;
    logic            scan_inc;
    logic            alloc_take;
    logic            rd_en;
    rd_sel_e         rd_sel;
    logic            capture;
    logic            step;
    logic            lw;
    tgt_e            lt;
    val_e            lv;
    logic            kw;
    logic            uset;
    logic            uclr;
    clr_e            clr_sel;
    logic            rs_set;
    rs_e             rs_sel;
    logic            st_set;
    logic [ST_W-1:0] st_val;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            head_zero;
    logic            cur_zero;
    logic            prv_zero;
    logic            lnk_zero;
    logic            sec_zero;
    logic            cur_is_sec;
    logic            rdn_zero;
    logic            key_eq;
    logic            key_ge;
    logic            scan_over;
    logic            scan_free;
    logic            addr_bad;
  } flags_t;

endpackage

`default_nettype wire

>>> sv/allm_dp.sv
// ----------------------------------------------------------------------------
// allm_dp
// Datapath: slot store memories, free map, list walk registers, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module allm_dp #(
  parameter int SLOTS     = allm_pkg::SLOTS_DEF,
  parameter int KEY_WIDTH = allm_pkg::KEY_WIDTH_DEF,
  localparam int SW = $clog2(SLOTS + 1),
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 2)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [allm_pkg::OP_W-1:0]   opcode_i,
  input  wire logic [KEY_WIDTH-1:0]        search_key_i,
  input  wire logic [KEY_WIDTH-1:0]        new_key_i,
  input  wire logic [SW-1:0]               slot_address_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [allm_pkg::CAP_W-1:0]  cfg_data_i,
  input  wire allm_pkg::cmd_t              cmd_i,
  output allm_pkg::flags_t                 flags_o,
  output logic [allm_pkg::ST_W-1:0]        status_o,
  output logic [SW-1:0]                    result_slot_o,
  output logic [KEY_WIDTH-1:0]             result_key_o
);

  localparam int LW = (CW > allm_pkg::CAP_W) ? CW : allm_pkg::CAP_W;

  logic [SW-1:0] next_mem [SLOTS];
  logic [KEY_WIDTH-1:0] key_mem [SLOTS];
  logic [SLOTS-1:0] used_q;

  logic [allm_pkg::CAP_W-1:0] cap_q;
  logic [SW-1:0] head_q, cur_q, prv_q, ppv_q, lnk_q, sec_q, fst_q;
  logic [SW-1:0] alloc_q, bslot_q, rs_q, addr_q, rdn_q;
  logic [CW-1:0] scan_q;
  logic [KEY_WIDTH-1:0] sk_q, nk_q, best_q, rdk_q;
  logic [allm_pkg::OP_W-1:0] op_q;
  logic [allm_pkg::ST_W-1:0] st_q;
  logic first_q;
  logic [allm_pkg::ST_W-1:0] out_st_q;
  logic [SW-1:0] out_slot_q;
  logic [KEY_WIDTH-1:0] out_key_q;

  logic [SW-1:0] rd_slot, tslot, lval, clr_slot, rs_d;
  logic [SW-1:0] rd_m1, t_m1, a_m1, c_m1, addr_m1;
  logic [CW-1:0] scan_m1;
  logic [LW-1:0] cap_ext, lim;
  logic better;

  always_comb begin
    unique case (cmd_i.rd_sel)
      allm_pkg::RD_CUR: rd_slot = cur_q;
      allm_pkg::RD_LNK: rd_slot = lnk_q;
      default:          rd_slot = rs_q;
    endcase
    case (cmd_i.lt)
      allm_pkg::TGT_S:   tslot = alloc_q;
      allm_pkg::TGT_C:   tslot = cur_q;
      allm_pkg::TGT_P:   tslot = prv_q;
      allm_pkg::TGT_PP:  tslot = ppv_q;
      allm_pkg::TGT_SEC: tslot = sec_q;
      allm_pkg::TGT_FST: tslot = fst_q;
      default:           tslot = '0;
    endcase
    unique case (cmd_i.lv)
      allm_pkg::VAL_ZERO: lval = '0;
      allm_pkg::VAL_S:    lval = alloc_q;
      allm_pkg::VAL_C:    lval = cur_q;
      allm_pkg::VAL_L:    lval = lnk_q;
      allm_pkg::VAL_RDN:  lval = rdn_q;
      allm_pkg::VAL_SEC:  lval = sec_q;
      allm_pkg::VAL_FST:  lval = fst_q;
      allm_pkg::VAL_HEAD: lval = head_q;
    endcase
    unique case (cmd_i.clr_sel)
      allm_pkg::CLR_C: clr_slot = cur_q;
      allm_pkg::CLR_P: clr_slot = prv_q;
      default:         clr_slot = lnk_q;
    endcase
    case (cmd_i.rs_sel)
      allm_pkg::RS_S:    rs_d = alloc_q;
      allm_pkg::RS_C:    rs_d = cur_q;
      allm_pkg::RS_P:    rs_d = prv_q;
      allm_pkg::RS_L:    rs_d = lnk_q;
      allm_pkg::RS_BEST: rs_d = bslot_q;
      allm_pkg::RS_HEAD: rs_d = head_q;
      default:           rs_d = addr_q;
    endcase
  end

  assign rd_m1   = rd_slot - 1'b1;
  assign t_m1    = tslot - 1'b1;
  assign a_m1    = alloc_q - 1'b1;
  assign c_m1    = clr_slot - 1'b1;
  assign addr_m1 = addr_q - 1'b1;
  assign scan_m1 = scan_q - 1'b1;

  assign cap_ext = LW'(cap_q);
  assign lim     = (cap_ext > LW'(SLOTS)) ? LW'(SLOTS) : cap_ext;

  assign better = first_q ||
                  ((op_q == allm_pkg::OP_MAX) ? (rdk_q > best_q) : (rdk_q < best_q));

  always_comb begin
    flags_o.op         = op_q;
    flags_o.head_zero  = (head_q == '0);
    flags_o.cur_zero   = (cur_q == '0);
    flags_o.prv_zero   = (prv_q == '0);
    flags_o.lnk_zero   = (lnk_q == '0);
    flags_o.sec_zero   = (sec_q == '0);
    flags_o.cur_is_sec = (cur_q == sec_q);
    flags_o.rdn_zero   = (rdn_q == '0);
    flags_o.key_eq     = (rdk_q == sk_q);
    flags_o.key_ge     = (rdk_q >= nk_q);
    flags_o.scan_over  = (LW'(scan_q) > lim);
    flags_o.scan_free  = !used_q[scan_m1[AW-1:0]];
    flags_o.addr_bad   = (addr_q == '0) || ({1'b0, addr_q} > (SW + 1)'(SLOTS)) ||
                         !used_q[addr_m1[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdn_q <= next_mem[rd_m1[AW-1:0]];
      rdk_q <= key_mem[rd_m1[AW-1:0]];
    end
    if (cmd_i.lw && (tslot != '0)) begin
      next_mem[t_m1[AW-1:0]] <= lval;
    end
    if (cmd_i.kw) begin
      key_mem[a_m1[AW-1:0]] <= nk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      used_q <= '0;
      cap_q  <= allm_pkg::CAP_RESET;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.lw && (tslot == '0)) begin
        head_q <= lval;
      end
      if (cmd_i.uset) begin
        used_q[a_m1[AW-1:0]] <= 1'b1;
      end
      if (cmd_i.uclr) begin
        used_q[c_m1[AW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      sk_q    <= search_key_i;
      nk_q    <= new_key_i;
      addr_q  <= slot_address_i;
      cur_q   <= head_q;
      fst_q   <= head_q;
      prv_q   <= '0;
      ppv_q   <= '0;
      first_q <= 1'b1;
      scan_q  <= CW'(1);
      rs_q    <= '0;
      st_q    <= allm_pkg::ST_OK;
    end
    if (cmd_i.scan_inc) begin
      scan_q <= scan_q + 1'b1;
    end
    if (cmd_i.alloc_take) begin
      alloc_q <= SW'(scan_q);
    end
    if (cmd_i.capture) begin
      lnk_q <= rdn_q;
      if (first_q) begin
        sec_q <= rdn_q;
      end
      if (better) begin
        best_q  <= rdk_q;
        bslot_q <= cur_q;
      end
    end
    if (cmd_i.step) begin
      ppv_q   <= prv_q;
      prv_q   <= cur_q;
      cur_q   <= rdn_q;
      first_q <= 1'b0;
    end
    if (cmd_i.rs_set) begin
      rs_q <= rs_d;
    end
    if (cmd_i.st_set) begin
      st_q <= cmd_i.st_val;
    end
    if (cmd_i.out_load) begin
      out_st_q   <= st_q;
      out_slot_q <= rs_q;
      out_key_q  <= (rs_q == '0) ? '0 : rdk_q;
    end
  end

  assign status_o      = out_st_q;
  assign result_slot_o = out_slot_q;
  assign result_key_o  = out_key_q;

endmodule

`default_nettype wire

>>> sv/allm_ctrl.sv
// ----------------------------------------------------------------------------
// allm_ctrl
// Controller: sequences allocation scan, list walk, relinking and result.
// ----------------------------------------------------------------------------
`default_nettype none

module allm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire allm_pkg::flags_t flags_i,
  output allm_pkg::cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SCAN, S_RD, S_EV, S_WEND, S_PL1, S_PL2,
    S_R7, S_SW1, S_SW2, S_SW3, S_SW4, S_KRD, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   stop;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    stop       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        case (flags_i.op)
          allm_pkg::OP_PUSH_FRONT, allm_pkg::OP_PUSH_BACK, allm_pkg::OP_INS_BEFORE,
          allm_pkg::OP_INS_AFTER, allm_pkg::OP_SORTED_INS: begin
            state_d = S_SCAN;
          end
          allm_pkg::OP_REMOVE, allm_pkg::OP_RM_BEFORE, allm_pkg::OP_RM_AFTER,
          allm_pkg::OP_RM_BACK, allm_pkg::OP_FIND, allm_pkg::OP_MAX,
          allm_pkg::OP_MIN, allm_pkg::OP_SWAP_ENDS: begin
            if (flags_i.head_zero) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = allm_pkg::ST_EMPTY;
              state_d      = S_FIN;
            end else begin
              state_d = S_RD;
            end
          end
          allm_pkg::OP_READ_SLOT: begin
            if (flags_i.addr_bad) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = allm_pkg::ST_NOT_IN_LIST;
              state_d      = S_FIN;
            end else begin
              cmd_o.rs_set = 1'b1;
              cmd_o.rs_sel = allm_pkg::RS_ADDR;
              state_d      = S_KRD;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_SCAN: begin
        priority if (flags_i.scan_over) begin
          cmd_o.st_set = 1'b1;
          cmd_o.st_val = allm_pkg::ST_FULL;
          state_d      = S_FIN;
        end else if (flags_i.scan_free) begin
          cmd_o.alloc_take = 1'b1;
          priority if (flags_i.op == allm_pkg::OP_PUSH_FRONT) begin
            state_d = S_PL1;
          end else if (((flags_i.op == allm_pkg::OP_INS_BEFORE) ||
                        (flags_i.op == allm_pkg::OP_INS_AFTER)) && flags_i.head_zero) begin
            cmd_o.st_set = 1'b1;
            cmd_o.st_val = allm_pkg::ST_EMPTY;
            state_d      = S_FIN;
          end else begin
            state_d = S_RD;
          end
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_RD: begin
        if (flags_i.cur_zero) begin
          state_d = S_WEND;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = allm_pkg::RD_CUR;
          state_d      = S_EV;
        end
      end
      S_EV: begin
        cmd_o.capture = 1'b1;
        case (flags_i.op)
          allm_pkg::OP_INS_BEFORE, allm_pkg::OP_INS_AFTER, allm_pkg::OP_REMOVE,
          allm_pkg::OP_RM_BEFORE, allm_pkg::OP_RM_AFTER, allm_pkg::OP_FIND:
            stop = flags_i.key_eq;
          allm_pkg::OP_PUSH_BACK, allm_pkg::OP_RM_BACK, allm_pkg::OP_SWAP_ENDS:
            stop = flags_i.rdn_zero;
          allm_pkg::OP_SORTED_INS:
            stop = flags_i.key_ge;
          default:
            stop = 1'b0;
        endcase
        if (stop) begin
          state_d = S_WEND;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_RD;
        end
      end
      S_WEND: begin
        case (flags_i.op)
          allm_pkg::OP_PUSH_BACK, allm_pkg::OP_SORTED_INS: state_d = S_PL1;
          allm_pkg::OP_INS_BEFORE, allm_pkg::OP_INS_AFTER: begin
            if (flags_i.cur_zero) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = allm_pkg::ST_NOT_FOUND;
              state_d      = S_FIN;
            end else begin
              state_d = S_PL1;
            end
          end
          allm_pkg::OP_REMOVE: begin
            if (flags_i.cur_zero) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = allm_pkg::ST_NOT_FOUND;
              state_d      = S_FIN;
            end else begin
              cmd_o.lw      = 1'b1;
              cmd_o.lt      = allm_pkg::TGT_P;
              cmd_o.lv      = allm_pkg::VAL_L;
              cmd_o.uclr    = 1'b1;
              cmd_o.clr_sel = allm_pkg::CLR_C;
              cmd_o.rs_set  = 1'b1;
              cmd_o.rs_sel  = allm_pkg::RS_C;
              state_d       = S_KRD;
            end
          end
          allm_pkg::OP_RM_BEFORE: begin
            priority if (flags_i.cur_zero) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = allm_pkg::ST_NOT_FOUND;
              state_d      = S_FIN;
            end else if (flags_i.prv_zero) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = allm_pkg::ST_NO_NEIGH;
              state_d      = S_FIN;
            end else begin
              cmd_o.lw      = 1'b1;
              cmd_o.lt      = allm_pkg::TGT_PP;
              cmd_o.lv      = allm_pkg::VAL_C;
              cmd_o.uclr    = 1'b1;
              cmd_o.clr_sel = allm_pkg::CLR_P;
              cmd_o.rs_set  = 1'b1;
              cmd_o.rs_sel  = allm_pkg::RS_P;
              state_d       = S_KRD;
            end
          end
          allm_pkg::OP_RM_AFTER: begin
            priority if (flags_i.cur_zero) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = allm_pkg::ST_NOT_FOUND;
              state_d      = S_FIN;
            end else if (flags_i.lnk_zero) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = allm_pkg::ST_NO_NEIGH;
              state_d      = S_FIN;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = allm_pkg::RD_LNK;
              cmd_o.rs_set = 1'b1;
              cmd_o.rs_sel = allm_pkg::RS_L;
              state_d      = S_R7;
            end
          end
          allm_pkg::OP_FIND: begin
            if (flags_i.cur_zero) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = allm_pkg::ST_NOT_FOUND;
              state_d      = S_FIN;
            end else begin
              cmd_o.rs_set = 1'b1;
              cmd_o.rs_sel = allm_pkg::RS_C;
              state_d      = S_KRD;
            end
          end
          allm_pkg::OP_RM_BACK: begin
            cmd_o.lw      = 1'b1;
            cmd_o.lt      = allm_pkg::TGT_P;
            cmd_o.lv      = allm_pkg::VAL_ZERO;
            cmd_o.uclr    = 1'b1;
            cmd_o.clr_sel = allm_pkg::CLR_C;
            cmd_o.rs_set  = 1'b1;
            cmd_o.rs_sel  = allm_pkg::RS_C;
            state_d       = S_KRD;
          end
          allm_pkg::OP_MAX, allm_pkg::OP_MIN: begin
            cmd_o.rs_set = 1'b1;
            cmd_o.rs_sel = allm_pkg::RS_BEST;
            state_d      = S_KRD;
          end
          allm_pkg::OP_SWAP_ENDS: begin
            if (flags_i.sec_zero) begin
              cmd_o.rs_set = 1'b1;
              cmd_o.rs_sel = allm_pkg::RS_HEAD;
              state_d      = S_KRD;
            end else begin
              state_d = S_SW1;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_R7: begin
        cmd_o.lw      = 1'b1;
        cmd_o.lt      = allm_pkg::TGT_C;
        cmd_o.lv      = allm_pkg::VAL_RDN;
        cmd_o.uclr    = 1'b1;
        cmd_o.clr_sel = allm_pkg::CLR_L;
        state_d       = S_KRD;
      end
      S_PL1: begin
        cmd_o.lw   = 1'b1;
        cmd_o.lt   = allm_pkg::TGT_S;
        cmd_o.kw   = 1'b1;
        cmd_o.uset = 1'b1;
        case (flags_i.op)
          allm_pkg::OP_PUSH_FRONT: cmd_o.lv = allm_pkg::VAL_HEAD;
          allm_pkg::OP_PUSH_BACK:  cmd_o.lv = allm_pkg::VAL_ZERO;
          allm_pkg::OP_INS_AFTER:  cmd_o.lv = allm_pkg::VAL_L;
          default:                 cmd_o.lv = allm_pkg::VAL_C;
        endcase
        state_d = S_PL2;
      end
      S_PL2: begin
        cmd_o.lw     = 1'b1;
        cmd_o.lv     = allm_pkg::VAL_S;
        cmd_o.rs_set = 1'b1;
        cmd_o.rs_sel = allm_pkg::RS_S;
        case (flags_i.op)
          allm_pkg::OP_PUSH_FRONT: cmd_o.lt = allm_pkg::TGT_HEAD;
          allm_pkg::OP_PUSH_BACK, allm_pkg::OP_INS_AFTER: cmd_o.lt = allm_pkg::TGT_C;
          default:                 cmd_o.lt = allm_pkg::TGT_P;
        endcase
        state_d = S_KRD;
      end
      S_SW1: begin
        cmd_o.lw = 1'b1;
        cmd_o.lt = allm_pkg::TGT_HEAD;
        cmd_o.lv = allm_pkg::VAL_C;
        state_d  = S_SW2;
      end
      S_SW2: begin
        cmd_o.lw = 1'b1;
        if (flags_i.cur_is_sec) begin
          cmd_o.lt = allm_pkg::TGT_SEC;
          cmd_o.lv = allm_pkg::VAL_FST;
          state_d  = S_SW4;
        end else begin
          cmd_o.lt = allm_pkg::TGT_C;
          cmd_o.lv = allm_pkg::VAL_SEC;
          state_d  = S_SW3;
        end
      end
      S_SW3: begin
        cmd_o.lw = 1'b1;
        cmd_o.lt = allm_pkg::TGT_P;
        cmd_o.lv = allm_pkg::VAL_FST;
        state_d  = S_SW4;
      end
      S_SW4: begin
        cmd_o.lw     = 1'b1;
        cmd_o.lt     = allm_pkg::TGT_FST;
        cmd_o.lv     = allm_pkg::VAL_ZERO;
        cmd_o.rs_set = 1'b1;
        cmd_o.rs_sel = allm_pkg::RS_HEAD;
        state_d      = S_KRD;
      end
      S_KRD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = allm_pkg::RD_RS;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> sv/array_linked_list_manager.sv
// ----------------------------------------------------------------------------
// array_linked_list_manager
// Singly linked list of keys in a fixed slot store with a free map.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_axis channel carries one operation (opcode in
//   tuser) and gives exactly one transfer on the m_axis channel with a
//   status, a slot and the key held in that slot.
//   The user must write the capacity register on the cfg channel only while
//   idle; the block itself does not enforce this. Work from the input
//   transfer to the result is a fixed sequence of states, plus a free-map
//   scan by the allocating operations that tests one slot per step and a
//   walk with one registered read of the link and key memories per list
//   node; a walk that runs off the tail takes one more step. The worst case
//   is a sorted insert into a nearly full store. One operation is in flight
//   at a time; the next is taken once its result sits in the output register.
//   Reset empties the list and frees every slot at once; capacity resets
//   to 64. No clearing pass is needed.
//   While m_axis is stalled the result holds; a further operation may be
//   taken and worked, and waits to finish until the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_linked_list_manager_macros.svh"

module array_linked_list_manager #(
  parameter int SLOTS     = allm_pkg::SLOTS_DEF,
  parameter int KEY_WIDTH = allm_pkg::KEY_WIDTH_DEF,
  localparam int SW  = $clog2(SLOTS + 1),
  localparam int IDW = ((2 * KEY_WIDTH + SW + 7) / 8) * 8,
  localparam int ODW = ((allm_pkg::ST_W + SW + KEY_WIDTH + 7) / 8) * 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // search_key, new_key, slot_address
  input  wire logic [IDW-1:0]             s_axis_tdata,
  // opcode
  input  wire logic [allm_pkg::OP_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // status, result_slot, result_key
  output logic [ODW-1:0]                  m_axis_tdata,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [allm_pkg::CAP_W-1:0] cfg_data_i
);

  allm_pkg::cmd_t   cmd;
  allm_pkg::flags_t flags;

  logic [allm_pkg::ST_W-1:0] status;
  logic [SW-1:0]             result_slot;
  logic [KEY_WIDTH-1:0]      result_key;

  assign cfg_ready_o = 1'b1;

  allm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  allm_dp #(
    .SLOTS     (SLOTS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (s_axis_tuser),
    .search_key_i   (s_axis_tdata[KEY_WIDTH-1:0]),
    .new_key_i      (s_axis_tdata[2*KEY_WIDTH-1:KEY_WIDTH]),
    .slot_address_i (s_axis_tdata[2*KEY_WIDTH+SW-1:2*KEY_WIDTH]),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .flags_o        (flags),
    .status_o       (status),
    .result_slot_o  (result_slot),
    .result_key_o   (result_key)
  );

  assign m_axis_tdata = ODW'({result_key, result_slot, status});

  `ALLM_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second operation taken while busy")
  `ALLM_ASSERT(a_no_overwrite, !cmd.out_load || !m_axis_tvalid || m_axis_tready, "result overwritten before transfer")
  `ALLM_ASSERT(a_load_on_transfer, !cmd.load || (s_axis_tvalid && s_axis_tready), "operation latched without transfer")

endmodule

`default_nettype wire
